// ===== hw/rtl/puf_pkg.sv =====
// Package for the persistent union-find engine.
// Holds the request/response payloads, memory entry layouts and FSM states.
// No dependencies.
`timescale 1ns / 1ps
package puf_pkg;

    localparam int ELEMENTS = 1024;
    localparam int IDX_W    = 10;
    localparam int PTR_W    = 11;
    localparam int TIME_W   = 32;
    localparam int SIZE_W   = 11;

    localparam logic [TIME_W-1:0] TIME_FULL = '1;
    localparam logic [PTR_W-1:0]  HIST_NULL = PTR_W'(ELEMENTS);

    localparam logic [1:0] FUNC_UNITE = 2'd0;
    localparam logic [1:0] FUNC_FIND  = 2'd1;
    localparam logic [1:0] FUNC_SAME  = 2'd2;
    localparam logic [1:0] FUNC_SIZE  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  first_elem;
        logic [IDX_W-1:0]  second_elem;
        logic [TIME_W-1:0] query_time;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  root;
        logic              same_set;
        logic [SIZE_W-1:0] set_size;
        logic [TIME_W-1:0] stamp;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic [IDX_W-1:0]  parent;
        logic [TIME_W-1:0] ltime;
        logic [SIZE_W-1:0] csize;
        logic [PTR_W-1:0]  head;
    } node_t;

    typedef struct packed {
        logic [TIME_W-1:0] htime;
        logic [SIZE_W-1:0] hsize;
        logic [PTR_W-1:0]  hprev;
    } hist_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_HIST,
        ST_LINK_Y,
        ST_LINK_X,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/puf_req_if.sv =====
// Request channel of the persistent union-find engine.
// Depends on puf_pkg for the payload type.
`timescale 1ns / 1ps
interface puf_req_if;
    logic          valid;
    logic          ready;
    puf_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/puf_rsp_if.sv =====
// Response channel of the persistent union-find engine.
// Depends on puf_pkg for the payload type.
`timescale 1ns / 1ps
interface puf_rsp_if;
    logic          valid;
    logic          ready;
    puf_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/puf_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read.
// Depends on puf_pkg for the depth.
`timescale 1ns / 1ps
module puf_ram #(
    parameter int WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [puf_pkg::IDX_W-1:0]     waddr,
    input  logic [WIDTH-1:0]              wdata,
    input  logic [puf_pkg::IDX_W-1:0]     raddr,
    output logic [WIDTH-1:0]              rdata
);
    import puf_pkg::*;

    logic [WIDTH-1:0] mem [ELEMENTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/persistent_union_find.sv =====
// Top level of the partially persistent union-find engine.
// Depends on puf_pkg, puf_req_if, puf_rsp_if and puf_ram.
`timescale 1ns / 1ps
// Usage:
// Requests enter on req (valid/ready) and carry func, first_elem, second_elem
// and query_time. Each request yields exactly one response on rsp.
// Unite joins the roots at the current time and returns the time before the
// step in stamp; find, same and size answer for the forest at query_time.
// A request walks from first_elem to its root; union by size keeps a walk
// within 10 links. Same and unite then walk from second_elem to its root,
// and a merging unite writes the absorbed root in ST_LINK_Y and the
// surviving root in ST_LINK_X. A size query then follows the root's history
// chain back to the newest entry not later than query_time; a root's chain
// holds one entry per merge into it.
// The block works on one request at a time; req.ready is high only while it
// waits for a request in the idle state. The node and history memories each
// have one read and one write port.
// After reset a clearing pass initializes every entry of the node memory;
// no request is taken during it. The response sits in an output register;
// while the receiver stalls, the block may take the next request and finish
// it, but holds that response until the register is free.
module persistent_union_find (
    input  logic     clk,
    input  logic     rst_n,
    puf_req_if.sink  req,
    puf_rsp_if.source rsp
);
    import puf_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [1:0]        func_reg, func_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [IDX_W-1:0]  ra_reg, ra_next;
    node_t             na_reg, na_next;
    logic [IDX_W-1:0]  x_reg, x_next;
    logic [IDX_W-1:0]  y_reg, y_next;
    node_t             xn_reg, xn_next;
    node_t             yn_reg, yn_next;
    logic [SIZE_W-1:0] sum_reg, sum_next;
    rsp_t              res_reg, res_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] tc_reg, tc_next;
    logic [PTR_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;

    logic              node_we, hist_we;
    logic [IDX_W-1:0]  node_waddr, hist_waddr, node_raddr, hist_raddr;
    node_t             node_wdata, node_rd;
    hist_t             hist_wdata, hist_rd;
    logic              linked;
    logic              hist_room;

    puf_ram #(.WIDTH($bits(node_t))) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rd)
    );

    puf_ram #(.WIDTH($bits(hist_t))) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rd)
    );

    // A node is linked at time t if its parent is not itself and ltime <= t.
    assign linked    = (node_rd.parent != cur_reg) && (node_rd.ltime <= t_reg);
    assign hist_room = (fill_reg < HIST_NULL);

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            tc_reg        <= '0;
            fill_reg      <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            tc_reg        <= tc_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        b_reg    <= b_next;
        func_reg <= func_next;
        t_reg    <= t_next;
        ra_reg   <= ra_next;
        na_reg   <= na_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        xn_reg   <= xn_next;
        yn_reg   <= yn_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        b_next         = b_reg;
        func_next      = func_reg;
        t_next         = t_reg;
        ra_next        = ra_reg;
        na_next        = na_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xn_next        = xn_reg;
        yn_next        = yn_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tc_next        = tc_reg;
        fill_next      = fill_reg;
        clr_next       = clr_reg;

        node_we    = 1'b0;
        node_waddr = clr_reg;
        node_wdata = '{parent: clr_reg, ltime: TIME_FULL, csize: SIZE_W'(1),
                       head: HIST_NULL};
        node_raddr = cur_reg;
        hist_we    = 1'b0;
        hist_waddr = fill_reg[IDX_W-1:0];
        hist_wdata = '{htime: tc_reg, hsize: sum_reg, hprev: xn_reg.head};
        hist_raddr = hist_rd.hprev[IDX_W-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                node_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.data.func;
                    b_next     = req.data.second_elem;
                    t_next     = req.data.query_time;
                    cur_next   = req.data.first_elem;
                    node_raddr = req.data.first_elem;
                    res_next   = '0;
                    state_next = ST_WALK_A;
                    if (req.data.func == FUNC_UNITE)
                    begin
                        if (tc_reg == TIME_FULL)
                        begin
                            res_next.status = STATUS_FULL;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            // Unite walks the forest as it stands now.
                            t_next         = tc_reg;
                            res_next.stamp = tc_reg;
                            tc_next        = tc_reg + 1'b1;
                        end
                    end
                end
            end

            ST_WALK_A:
            begin
                if (linked)
                begin
                    cur_next   = node_rd.parent;
                    node_raddr = node_rd.parent;
                end
                else
                begin
                    ra_next = cur_reg;
                    na_next = node_rd;
                    case (func_reg)
                        FUNC_UNITE, FUNC_SAME:
                        begin
                            cur_next   = b_reg;
                            node_raddr = b_reg;
                            state_next = ST_WALK_B;
                        end
                        FUNC_FIND:
                        begin
                            res_next.root = cur_reg;
                            state_next    = ST_DONE;
                        end
                        default:
                        begin
                            if (node_rd.head == HIST_NULL)
                            begin
                                res_next.set_size = SIZE_W'(1);
                                state_next        = ST_DONE;
                            end
                            else
                            begin
                                hist_raddr = node_rd.head[IDX_W-1:0];
                                state_next = ST_HIST;
                            end
                        end
                    endcase
                end
            end

            ST_WALK_B:
            begin
                if (linked)
                begin
                    cur_next   = node_rd.parent;
                    node_raddr = node_rd.parent;
                end
                else if (func_reg == FUNC_SAME)
                begin
                    res_next.same_set = (ra_reg == cur_reg);
                    state_next        = ST_DONE;
                end
                else if (ra_reg == cur_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sum_next = na_reg.csize + node_rd.csize;
                    if (na_reg.csize < node_rd.csize)
                    begin
                        x_next  = cur_reg;
                        xn_next = node_rd;
                        y_next  = ra_reg;
                        yn_next = na_reg;
                    end
                    else
                    begin
                        x_next  = ra_reg;
                        xn_next = na_reg;
                        y_next  = cur_reg;
                        yn_next = node_rd;
                    end
                    state_next = ST_LINK_Y;
                end
            end

            ST_HIST:
            begin
                if (hist_rd.htime <= t_reg)
                begin
                    res_next.set_size = hist_rd.hsize;
                    state_next        = ST_DONE;
                end
                else if (hist_rd.hprev == HIST_NULL)
                begin
                    res_next.set_size = SIZE_W'(1);
                    state_next        = ST_DONE;
                end
            end

            ST_LINK_Y:
            begin
                node_we    = 1'b1;
                node_waddr = y_reg;
                node_wdata = '{parent: x_reg, ltime: tc_reg, csize: yn_reg.csize,
                               head: yn_reg.head};
                state_next = ST_LINK_X;
            end

            ST_LINK_X:
            begin
                node_we    = 1'b1;
                node_waddr = x_reg;
                node_wdata = '{parent: xn_reg.parent, ltime: xn_reg.ltime,
                               csize: sum_reg,
                               head: hist_room ? fill_reg : xn_reg.head};
                if (hist_room)
                begin
                    hist_we   = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_tc_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tc_reg) |-> tc_reg == $past(tc_reg) + 1'b1)
        else $error("time counter moved by other than one");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= HIST_NULL)
        else $error("history fill past the pool size");

    a_hist_write: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |-> (state_reg == ST_LINK_X) && (x_reg != y_reg))
        else $error("history written outside a merge");

    a_no_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_valid_reg && !rsp.ready |=> state_reg == ST_DONE)
        else $error("response dropped while receiver stalls");
`endif
endmodule

// ===== verif/tb_persistent_union_find.sv =====
// Self-checking testbench for the partially persistent union-find engine.
// It predicts every response in a scoreboard class and drives request and response channels.
// Depends on puf_pkg, puf_req_if, puf_rsp_if and the persistent_union_find RTL.
`timescale 1ns / 1ps
module tb_persistent_union_find;
    import puf_pkg::*;

    localparam int  NUM_RANDOM  = 1130;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam logic [TIME_W-1:0] NEVER = '1;

    class uf_scoreboard;
        logic [IDX_W-1:0]  parent_of [ELEMENTS];
        logic [TIME_W-1:0] linked_at [ELEMENTS];
        logic [SIZE_W-1:0] live_size [ELEMENTS];
        logic [PTR_W-1:0]  chain_head [ELEMENTS];
        logic [TIME_W-1:0] entry_time [ELEMENTS];
        logic [SIZE_W-1:0] entry_size [ELEMENTS];
        logic [PTR_W-1:0]  entry_prev [ELEMENTS];
        int                entries_used;
        logic [TIME_W-1:0] now;
        rsp_t              expected_rsps[$];
        int                mismatches;
        int                unites;
        int                merges;
        int                queries;

        function new();
            for (int i = 0; i < ELEMENTS; i++)
            begin
                parent_of[i]  = IDX_W'(i);
                linked_at[i]  = NEVER;
                live_size[i]  = SIZE_W'(1);
                chain_head[i] = HIST_NULL;
            end
            entries_used = 0;
            now          = '0;
            mismatches   = 0;
            unites       = 0;
            merges       = 0;
            queries      = 0;
        endfunction

        function logic [IDX_W-1:0] root_at(logic [TIME_W-1:0] t, logic [IDX_W-1:0] e);
            for (int s = 0; s < ELEMENTS; s++)
            begin
                if (parent_of[e] == e || linked_at[e] > t)
                    break;
                e = parent_of[e];
            end
            return e;
        endfunction

        function logic [SIZE_W-1:0] size_at(logic [TIME_W-1:0] t, logic [IDX_W-1:0] r);
            logic [PTR_W-1:0] ent;
            ent = chain_head[r];
            for (int s = 0; s < ELEMENTS && ent < HIST_NULL; s++)
            begin
                if (entry_time[ent] <= t)
                    return entry_size[ent];
                ent = entry_prev[ent];
            end
            return SIZE_W'(1);
        endfunction

        function void note_request(req_t r);
            rsp_t             x;
            logic [IDX_W-1:0] ra;
            logic [IDX_W-1:0] rb;
            logic [IDX_W-1:0] sw;
            x = '0;
            case (r.func)
                FUNC_UNITE:
                begin
                    unites++;
                    if (now == TIME_FULL)
                        x.status = STATUS_FULL;
                    else
                    begin
                        ra = root_at(now, r.first_elem);
                        rb = root_at(now, r.second_elem);
                        x.stamp = now;
                        now = now + 1;
                        if (ra != rb)
                        begin
                            merges++;
                            if (live_size[ra] < live_size[rb])
                            begin
                                sw = ra;
                                ra = rb;
                                rb = sw;
                            end
                            live_size[ra] = live_size[ra] + live_size[rb];
                            parent_of[rb] = ra;
                            linked_at[rb] = now;
                            if (entries_used < ELEMENTS)
                            begin
                                entry_time[entries_used] = now;
                                entry_size[entries_used] = live_size[ra];
                                entry_prev[entries_used] = chain_head[ra];
                                chain_head[ra] = PTR_W'(entries_used);
                                entries_used++;
                            end
                        end
                    end
                end
                FUNC_FIND:
                begin
                    queries++;
                    x.root = root_at(r.query_time, r.first_elem);
                end
                FUNC_SAME:
                begin
                    queries++;
                    x.same_set = (root_at(r.query_time, r.first_elem)
                                  == root_at(r.query_time, r.second_elem));
                end
                default:
                begin
                    queries++;
                    x.set_size = size_at(r.query_time, root_at(r.query_time, r.first_elem));
                end
            endcase
            expected_rsps = {expected_rsps, x};
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response %p", got);
                return;
            end
            want = expected_rsps.pop_front();
            if (got.root !== want.root || got.same_set !== want.same_set
                || got.set_size !== want.set_size || got.stamp !== want.stamp
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response mismatch, expected %p, got %p", want, got);
            end
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    bit   long_hold_done;
    int   burst_left;
    int   sent;
    uf_scoreboard sb;

    puf_req_if req();
    puf_rsp_if rsp();

    persistent_union_find u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Accepted traffic on both channels feeds the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.data);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.data);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL persistent_union_find");
            $finish;
        end
    end

    // Receiver: changes its stall pattern every so often, and once holds off
    // for a long stretch so that the engine backs up and stops taking requests.
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        long_hold_done = 1'b0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            if (!long_hold_done && sent > 300)
            begin
                rsp.ready <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 1) == 1);
                    2: rsp.ready <= ($urandom_range(0, 5) == 0);
                    default: rsp.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_request(logic [1:0] f, logic [IDX_W-1:0] a,
                                logic [IDX_W-1:0] b, logic [TIME_W-1:0] t);
        req_t r;
        int   gap;
        r.func        = f;
        r.first_elem  = a;
        r.second_elem = b;
        r.query_time  = t;
        req.valid <= 1'b1;
        req.data  <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    function automatic logic [IDX_W-1:0] pick_elem(int window_base, int window_len);
        if ($urandom_range(0, 9) < 7)
            return IDX_W'(window_base + $urandom_range(0, window_len - 1));
        return IDX_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] pick_time(logic [TIME_W-1:0] now);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return NEVER;
        if (k == 1)
            return $urandom;
        if (k == 2)
            return NEVER - 1;
        return $urandom_range(0, (now > 32'hFFFF_FFF0) ? now : now + 2);
    endfunction

    initial
    begin
        int base;
        int span;
        int k;
        logic [1:0] f;
        burst_left = 0;
        sent = 0;
        req.valid = 1'b0;
        req.data  = '0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: extremes of the indices, the unite of one set, queries
        // before any link, at the newest time and at time all ones.
        send_request(FUNC_SIZE,  10'd0,    10'd0,    32'd0);
        send_request(FUNC_FIND,  10'd1023, 10'd0,    NEVER);
        send_request(FUNC_UNITE, 10'd0,    10'd1023, 32'd0);
        send_request(FUNC_UNITE, 10'd1023, 10'd0,    NEVER);
        send_request(FUNC_UNITE, 10'd5,    10'd5,    32'd0);
        send_request(FUNC_UNITE, 10'd1,    10'd2,    32'd0);
        send_request(FUNC_UNITE, 10'd2,    10'd1023, 32'd0);
        send_request(FUNC_UNITE, 10'd3,    10'd4,    32'd0);
        send_request(FUNC_UNITE, 10'd4,    10'd0,    32'd0);
        for (int t = 0; t < 8; t++)
        begin
            send_request(FUNC_FIND, 10'd1023, 10'd0, 32'(t));
            send_request(FUNC_SIZE, 10'd1, 10'd0, 32'(t));
        end
        send_request(FUNC_SAME, 10'd3, 10'd1023, 32'd2);
        send_request(FUNC_SAME, 10'd3, 10'd1023, NEVER);
        send_request(FUNC_SIZE, 10'd6, 10'd0, NEVER);
        send_request(FUNC_FIND, 10'd4, 10'd0, 32'hFFFF_FFFE);
        send_request(FUNC_SAME, 10'd512, 10'd511, 32'h8000_0000);

        base = 0;
        span = 16;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 120 == 0)
            begin
                span = 1 << $urandom_range(2, 7);
                base = $urandom_range(0, ELEMENTS - span);
            end
            if (n == NUM_RANDOM / 2)
            begin
                // Let the engine drain completely before going on.
                req.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            k = $urandom_range(0, 9);
            f = (k < 4) ? FUNC_UNITE : (k < 6) ? FUNC_FIND : (k < 8) ? FUNC_SAME : FUNC_SIZE;
            send_request(f, pick_elem(base, span), pick_elem(base, span), pick_time(sb.now));
        end
        req.valid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Covered %0d requests: %0d unites (%0d merges), %0d queries.",
                 sent, sb.unites, sb.merges, sb.queries);
        $display("Mismatches: %0d, responses still owed: %0d.", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS persistent_union_find");
        else
            $display("FAIL persistent_union_find");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/puf_pkg.sv
hw/rtl/puf_req_if.sv
hw/rtl/puf_rsp_if.sv
hw/rtl/puf_ram.sv
hw/rtl/persistent_union_find.sv
verif/tb_persistent_union_find.sv
